// ===== rtl/sbfd_pkg.sv =====
`timescale 1ns / 1ps
package sbfd_pkg;

	localparam int unsigned FRAME_LEN    = 25;
	localparam int unsigned NUM_CH       = 16;
	localparam int unsigned CH_W         = 11;
	localparam int unsigned CH_DATA_W    = NUM_CH * CH_W;
	localparam int unsigned DATA_BYTES   = CH_DATA_W / 8;
	localparam int unsigned FILL_W       = $clog2(FRAME_LEN);
	localparam int unsigned CH_IDX_W     = $clog2(NUM_CH);

	localparam logic [FILL_W-1:0]   FILL_FULL   = FILL_W'(FRAME_LEN - 1);
	localparam logic [CH_IDX_W-1:0] CH_IDX_LAST = CH_IDX_W'(NUM_CH - 1);

	localparam logic [7:0] HEADER_BYTE   = 8'h0F;
	localparam logic [7:0] END_BYTE_ZERO = 8'h00;
	localparam int unsigned FAILSAFE_BIT = 3;
	localparam logic [7:0] END_MARKER [4] = '{8'h04, 8'h14, 8'h24, 8'h34};

	localparam logic [15:0] GAP_LIMIT_RST     = 16'd2500;
	localparam logic [15:0] OFFLINE_LIMIT_RST = 16'd500;
	localparam logic [10:0] CENTER_RST        = 11'd1000;
	localparam logic [9:0]  GAIN_RST          = 10'd659;

	localparam logic OP_BYTE      = 1'b0;
	localparam logic OP_TICK      = 1'b1;
	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [1:0] {
		REG_GAP_LIMIT     = 2'd0,
		REG_OFFLINE_LIMIT = 2'd1,
		REG_CENTER_OFFSET = 2'd2,
		REG_GAIN          = 2'd3
	} sbfd_reg_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_FRAME  = 2'd1,
		EV_STATUS = 2'd2
	} sbfd_ev_kind_t;

	typedef struct packed {
		logic        operation;
		logic [7:0]  byte_value;
		logic [31:0] time_us;
		logic [7:0]  elapsed_ms;
	} sbfd_in_t;

	typedef struct packed {
		logic                     result_kind;
		logic [3:0]               channel_index;
		logic [10:0]              raw_value;
		logic signed [11:0]       scaled_value;
		logic                     scaled_valid;
		logic [7:0]               flag_byte;
		logic                     link_offline;
		logic                     last;
	} sbfd_out_t;

	typedef struct packed {
		logic [15:0] gap_limit_us;
		logic [15:0] offline_limit_ms;
		logic [10:0] center_offset;
		logic [9:0]  gain_q10;
	} sbfd_cfg_t;

	typedef struct packed {
		logic                 valid;
		sbfd_ev_kind_t        kind;
		logic [CH_DATA_W-1:0] chan_data;
		logic [7:0]           flags;
		logic                 offline;
	} sbfd_evt_t;

endpackage

// ===== rtl/sbfd_cfg_regs.sv =====
`timescale 1ns / 1ps
module sbfd_cfg_regs import sbfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output sbfd_cfg_t   cfg
);

	sbfd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit_us     <= GAP_LIMIT_RST;
			cfg_q.offline_limit_ms <= OFFLINE_LIMIT_RST;
			cfg_q.center_offset    <= CENTER_RST;
			cfg_q.gain_q10         <= GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (sbfd_reg_t'(cfg_index))
				REG_GAP_LIMIT:     cfg_q.gap_limit_us     <= cfg_data;
				REG_OFFLINE_LIMIT: cfg_q.offline_limit_ms <= cfg_data;
				REG_CENTER_OFFSET: cfg_q.center_offset    <= cfg_data[10:0];
				REG_GAIN:          cfg_q.gain_q10         <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/sbfd_frame_tracker.sv =====
`timescale 1ns / 1ps
module sbfd_frame_tracker import sbfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  sbfd_in_t  item,
	input  sbfd_cfg_t cfg,
	output sbfd_evt_t evt,
	input  logic      evt_ready
);

	sbfd_in_t          item_s1;
	logic              valid_s1;
	logic [7:0]        shift_q [FRAME_LEN];
	logic [FILL_W-1:0] fill_q;
	logic [31:0]       prev_time_q;
	logic [1:0]        marker_q;
	logic [15:0]       timer_q;
	logic              offline_q;

	logic              s1_fire;
	logic              is_tick;
	logic [31:0]       gap;
	logic              gap_restart;
	logic [FILL_W-1:0] fill_base;
	logic              window_full;
	logic              end_ok;
	logic              frame_hit;
	logic              good;
	logic [16:0]       timer_sum;
	logic              timer_below;
	logic              offline_next;

	assign s1_fire    = valid_s1 && evt_ready;
	assign item_ready = !valid_s1 || s1_fire;

	assign is_tick     = item_s1.operation == OP_TICK;
	assign gap         = item_s1.time_us - prev_time_q;
	assign gap_restart = gap > {16'd0, cfg.gap_limit_us};
	assign fill_base   = gap_restart ? '0 : fill_q;
	assign window_full = fill_base == FILL_FULL;
	// the incoming byte becomes window byte 24, shift_q[1] becomes byte 0
	assign end_ok      = item_s1.byte_value == END_BYTE_ZERO ||
	                     item_s1.byte_value == END_MARKER[marker_q];
	assign frame_hit   = !is_tick && window_full && shift_q[1] == HEADER_BYTE && end_ok;
	assign good        = !shift_q[FRAME_LEN-1][FAILSAFE_BIT];

	assign timer_sum   = {1'b0, timer_q} + {9'd0, item_s1.elapsed_ms};
	assign timer_below = timer_q < cfg.offline_limit_ms;

	always_comb begin
		offline_next = offline_q;
		if (is_tick) begin
			if (!timer_below) begin
				offline_next = 1'b1;
			end
		end else if (frame_hit && good) begin
			offline_next = 1'b0;
		end
	end

	always_comb begin
		evt.valid   = valid_s1;
		evt.kind    = is_tick ? EV_STATUS : (frame_hit ? EV_FRAME : EV_NONE);
		evt.flags   = shift_q[FRAME_LEN-1];
		evt.offline = offline_next;
		for (int i = 0; i < DATA_BYTES; i++) begin
			evt.chan_data[i*8 +: 8] = shift_q[i+2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (s1_fire && !is_tick) begin
			for (int i = 0; i < FRAME_LEN - 1; i++) begin
				shift_q[i] <= shift_q[i+1];
			end
			shift_q[FRAME_LEN-1] <= item_s1.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			prev_time_q <= '0;
			marker_q    <= '0;
			timer_q     <= '0;
			offline_q   <= 1'b0;
		end else if (s1_fire) begin
			offline_q <= offline_next;
			if (is_tick) begin
				if (timer_below) begin
					timer_q <= timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
				end
			end else begin
				prev_time_q <= item_s1.time_us;
				if (frame_hit) begin
					fill_q   <= '0;
					marker_q <= marker_q + 2'd1;
					if (good) begin
						timer_q <= '0;
					end
				end else if (window_full) begin
					fill_q <= FILL_FULL;
				end else begin
					fill_q <= fill_base + FILL_W'(1);
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FILL_FULL)
		else $error("fill count beyond frame length");

endmodule

// ===== rtl/sbfd_channel_emitter.sv =====
`timescale 1ns / 1ps
module sbfd_channel_emitter import sbfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sbfd_evt_t evt,
	output logic      evt_ready,
	input  sbfd_cfg_t cfg,
	output logic      result_valid,
	input  logic      result_ready,
	output sbfd_out_t result
);

	logic [CH_DATA_W-1:0] data_q;
	logic [CH_IDX_W-1:0]  ch_q;
	logic                 busy_q;
	logic [7:0]           flags_q;
	logic                 good_q;
	logic                 offline_q;
	sbfd_out_t            res_q;
	logic                 res_valid_q;

	logic                 load_out;
	logic                 evt_fire;
	logic                 frame_load;
	logic                 status_load;
	logic                 emit_ch;
	logic [CH_W-1:0]      raw;
	logic signed [11:0]   diff;
	logic signed [22:0]   prod;
	logic signed [22:0]   adj;
	logic                 ch_valid;
	sbfd_out_t            ch_res;
	sbfd_out_t            st_res;

	assign load_out = !res_valid_q || result_ready;

	always_comb begin
		case (evt.kind)
			EV_NONE:   evt_ready = 1'b1;
			EV_FRAME:  evt_ready = !busy_q;
			EV_STATUS: evt_ready = !busy_q && load_out;
			default:   evt_ready = 1'b1;
		endcase
	end

	assign evt_fire    = evt.valid && evt_ready;
	assign frame_load  = evt_fire && evt.kind == EV_FRAME;
	assign status_load = evt_fire && evt.kind == EV_STATUS;
	assign emit_ch     = busy_q && load_out;

	// scaled = (raw - center) * gain / 1024, truncated toward zero
	assign raw      = data_q[CH_W-1:0];
	assign diff     = $signed({1'b0, raw}) - $signed({1'b0, cfg.center_offset});
	assign prod     = 23'(diff) * 23'($signed({1'b0, cfg.gain_q10}));
	assign adj      = prod + (prod[22] ? 23'sd1023 : 23'sd0);
	assign ch_valid = good_q && !ch_q[CH_IDX_W-1];

	always_comb begin
		ch_res.result_kind   = KIND_CHANNEL;
		ch_res.channel_index = ch_q;
		ch_res.raw_value     = raw;
		ch_res.scaled_value  = ch_valid ? adj[21:10] : 12'sd0;
		ch_res.scaled_valid  = ch_valid;
		ch_res.flag_byte     = flags_q;
		ch_res.link_offline  = offline_q;
		ch_res.last          = ch_q == CH_IDX_LAST;

		st_res.result_kind   = KIND_STATUS;
		st_res.channel_index = '0;
		st_res.raw_value     = '0;
		st_res.scaled_value  = 12'sd0;
		st_res.scaled_valid  = 1'b0;
		st_res.flag_byte     = '0;
		st_res.link_offline  = evt.offline;
		st_res.last          = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ch_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (frame_load) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (emit_ch) begin
				ch_q <= ch_q + CH_IDX_W'(1);
				if (ch_q == CH_IDX_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (emit_ch || status_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_load) begin
			data_q    <= evt.chan_data;
			flags_q   <= evt.flags;
			good_q    <= !evt.flags[FAILSAFE_BIT];
			offline_q <= evt.offline;
		end else if (emit_ch) begin
			data_q <= data_q >> CH_W;
		end
		if (emit_ch) begin
			res_q <= ch_res;
		end else if (status_load) begin
			res_q <= st_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		frame_load |=> busy_q && ch_q == '0)
		else $error("frame load did not start channel sequence");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit_ch && ch_q == CH_IDX_LAST |=> !busy_q)
		else $error("emitter busy after last channel");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.scaled_valid |->
			result.result_kind == KIND_CHANNEL && !result.channel_index[CH_IDX_W-1])
		else $error("scaled value on wrong result");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.last ==
			(result.result_kind == KIND_STATUS || result.channel_index == CH_IDX_LAST))
		else $error("last marker mismatch");

endmodule

// ===== rtl/sbus_frame_decoder.sv =====
`timescale 1ns / 1ps
// Serial bus frame decoder. Each request is either a received byte with its microsecond
// timestamp or a millisecond tick. A byte that does not complete a valid 25-byte frame
// does not wait for the output side and gives no result. A byte that completes a frame
// yields sixteen channel results, one per cycle while the output register can be loaded,
// shifted out of a channel register with one 12x11 scaling multiply per result; the next
// frame or tick waits until the last channel is registered. A tick gives one status result.
// A request is registered in the tracker and then in the output register, a frame's channels
// also in the channel register; the output register lets bytes move on while a result waits.
module sbus_frame_decoder import sbfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  sbfd_in_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output sbfd_out_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sbfd_cfg_t cfg;
	sbfd_evt_t evt;
	logic      evt_ready;

	sbfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbfd_frame_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg        (cfg),
		.evt        (evt),
		.evt_ready  (evt_ready)
	);

	sbfd_channel_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt          (evt),
		.evt_ready    (evt_ready),
		.cfg          (cfg),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
